FILE: rtl/tspd_pkg.sv
`timescale 1ns / 1ps

package tspd_pkg;

	localparam logic [15:0] ISO_BYTES = 16'd256;
	localparam logic [3:0]  ISO_ROWS  = 4'd15;

	typedef struct packed {
		logic [7:0]         data_byte;
		logic               first_byte;
		logic               isometric;
		logic signed [15:0] origin_x;
		logic signed [15:0] origin_y;
		logic [15:0]        data_length;
	} item_t;

	typedef struct packed {
		logic signed [15:0] pixel_x;
		logic signed [15:0] pixel_y;
		logic [7:0]         pixel_value;
	} pixel_t;

	typedef struct packed {
		logic   valid;
		pixel_t pixel;
	} result_t;

	// first column of each diamond row
	function automatic logic [7:0] iso_start(input logic [3:0] row);
		logic [7:0] v;
		unique case (row)
			4'd0, 4'd14: v = 8'd14;
			4'd1, 4'd13: v = 8'd12;
			4'd2, 4'd12: v = 8'd10;
			4'd3, 4'd11: v = 8'd8;
			4'd4, 4'd10: v = 8'd6;
			4'd5, 4'd9:  v = 8'd4;
			4'd6, 4'd8:  v = 8'd2;
			default:     v = 8'd0;
		endcase
		return v;
	endfunction

	// pixel count of each diamond row
	function automatic logic [5:0] iso_count(input logic [3:0] row);
		logic [5:0] v;
		unique case (row)
			4'd0, 4'd14: v = 6'd4;
			4'd1, 4'd13: v = 6'd8;
			4'd2, 4'd12: v = 6'd12;
			4'd3, 4'd11: v = 6'd16;
			4'd4, 4'd10: v = 6'd20;
			4'd5, 4'd9:  v = 6'd24;
			4'd6, 4'd8:  v = 6'd28;
			4'd7:        v = 6'd32;
			default:     v = 6'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/tile_subtile_pixel_decoder.sv
`timescale 1ns / 1ps

// sub-tile pixel decoder
// slave stream s_*: one data byte of a sub-tile per item, with its origin,
//   its length and two flags; first_byte restarts the decoder for a new
//   sub-tile, isometric picks the fixed diamond layout over run-length pairs
// master stream m_*: one pixel write (x, y, palette index) per drawn byte;
//   skip/count bytes, bytes past the end and ignored sub-tiles give no item
// path: an accepted byte that draws goes through the input register, then
//   is decoded into the output register that drives m_tvalid
// throughput: one byte per cycle while m_tready does not stall the output; the
//   counters update with single adds in the decode stage, so nothing else limits the rate
// reset: the decoder sits in its done state and ignores bytes until one
//   with first_byte set arrives; both stream registers come up empty
// stall: while m_tready is low the pixel is held, the input register takes
//   one more byte if it is empty, and s_tready then drops until the pixel is taken
module tile_subtile_pixel_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// data_byte, origin_x, origin_y, data_length
	input  logic [55:0] s_tdata,
	// first_byte, isometric
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// pixel_x, pixel_y, pixel_value
	output logic [39:0] m_tdata
);
	import tspd_pkg::*;

	item_t   in_item;
	item_t   item_s1;
	result_t result;
	pixel_t  pixel_q;
	logic    advance;
	logic    step;

	always_comb begin
		in_item.data_byte   = s_tdata[7:0];
		in_item.origin_x    = signed'(s_tdata[23:8]);
		in_item.origin_y    = signed'(s_tdata[39:24]);
		in_item.data_length = s_tdata[55:40];
		in_item.first_byte  = s_tuser[0];
		in_item.isometric   = s_tuser[1];
	end

	tspd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.advance  (advance),
		.step     (step),
		.item_s1  (item_s1)
	);

	tspd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.result (result)
	);

	tspd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.result    (result),
		.advance   (advance),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.pixel_q   (pixel_q)
	);

	assign m_tdata = {pixel_q.pixel_value, pixel_q.pixel_y, pixel_q.pixel_x};

endmodule

FILE: rtl/tspd_in_reg.sv
`timescale 1ns / 1ps

module tspd_in_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  tspd_pkg::item_t in_item,
	input  logic           advance,
	output logic           step,
	output tspd_pkg::item_t item_s1
);
	import tspd_pkg::*;

	logic valid_s1;

	assign in_ready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

FILE: rtl/tspd_core.sv
`timescale 1ns / 1ps

module tspd_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  tspd_pkg::item_t   item,
	output tspd_pkg::result_t result
);
	import tspd_pkg::*;

	typedef enum logic [1:0] {
		PH_DONE  = 2'd0,
		PH_SKIP  = 2'd1,
		PH_COUNT = 2'd2,
		PH_DRAW  = 2'd3
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  skip_q, skip_d;
	logic [7:0]  run_q, run_d;
	logic [15:0] col_q, col_d;
	logic [15:0] row_q, row_d;
	logic [16:0] bytes_q, bytes_d;
	logic [3:0]  irow_q, irow_d;
	logic [5:0]  ileft_q, ileft_d;

	logic [15:0] emit_col;
	logic [15:0] emit_row;
	logic        emit;
	logic [8:0]  take_n;
	logic [17:0] take_diff;

	always_comb begin
		phase_d  = phase_q;
		skip_d   = skip_q;
		run_d    = run_q;
		col_d    = col_q;
		row_d    = row_q;
		bytes_d  = bytes_q;
		irow_d   = irow_q;
		ileft_d  = ileft_q;
		emit     = 1'b0;
		emit_col = col_q;
		emit_row = row_q;
		take_n   = 9'd2 + {1'b0, item.data_byte};
		take_diff = '0;

		// restart on the first byte of a sub-tile
		if (item.first_byte) begin
			skip_d  = '0;
			run_d   = '0;
			row_d   = '0;
			irow_d  = '0;
			bytes_d = {1'b0, item.data_length};
			if (item.isometric) begin
				if (item.data_length != ISO_BYTES) begin
					phase_d = PH_DONE;
					col_d   = '0;
					ileft_d = '0;
				end else begin
					col_d   = {8'd0, iso_start(4'd0)};
					ileft_d = iso_count(4'd0);
					phase_d = PH_DRAW;
				end
			end else begin
				col_d   = '0;
				ileft_d = '0;
				phase_d = (item.data_length == 16'd0) ? PH_DONE : PH_SKIP;
			end
		end

		if (phase_d != PH_DONE) begin
			if (item.isometric) begin
				if (irow_d >= ISO_ROWS) begin
					phase_d = PH_DONE;
				end else begin
					emit     = 1'b1;
					emit_col = col_d;
					emit_row = {12'd0, irow_d};
					col_d    = col_d + 16'd1;
					bytes_d  = (bytes_d > 17'd1) ? bytes_d - 17'd1 : 17'd0;
					if (ileft_d > 6'd1) begin
						ileft_d = ileft_d - 6'd1;
					end else begin
						irow_d = irow_d + 4'd1;
						if (irow_d >= ISO_ROWS) begin
							ileft_d = '0;
							phase_d = PH_DONE;
						end else begin
							ileft_d = iso_count(irow_d);
							col_d   = {8'd0, iso_start(irow_d)};
						end
					end
				end
			end else begin
				unique case (phase_d)
					PH_SKIP: begin
						skip_d  = item.data_byte;
						phase_d = PH_COUNT;
					end
					PH_COUNT: begin
						// pair bytes and run bytes taken in one saturating subtract
						take_diff = {1'b0, bytes_d} - {9'd0, take_n};
						bytes_d   = take_diff[17] ? 17'd0 : take_diff[16:0];
						if (skip_d != 8'd0 || item.data_byte != 8'd0) begin
							col_d = col_d + {8'd0, skip_d};
							run_d = item.data_byte;
							if (item.data_byte != 8'd0) begin
								phase_d = PH_DRAW;
							end else begin
								phase_d = (bytes_d == 17'd0) ? PH_DONE : PH_SKIP;
							end
						end else begin
							// zero/zero pair: next row
							col_d   = '0;
							row_d   = row_d + 16'd1;
							phase_d = (bytes_d == 17'd0) ? PH_DONE : PH_SKIP;
						end
					end
					PH_DRAW: begin
						emit     = 1'b1;
						emit_col = col_d;
						emit_row = row_d;
						col_d    = col_d + 16'd1;
						if (run_d > 8'd1) begin
							run_d = run_d - 8'd1;
						end else begin
							run_d   = '0;
							phase_d = (bytes_d == 17'd0) ? PH_DONE : PH_SKIP;
						end
					end
					PH_DONE: begin
					end
				endcase
			end
		end

		result.valid             = emit;
		result.pixel.pixel_x     = item.origin_x + signed'(emit_col);
		result.pixel.pixel_y     = item.origin_y + signed'(emit_row);
		result.pixel.pixel_value = item.data_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DONE;
			skip_q  <= '0;
			run_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
			bytes_q <= '0;
			irow_q  <= '0;
			ileft_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			skip_q  <= skip_d;
			run_q   <= run_d;
			col_q   <= col_d;
			row_q   <= row_d;
			bytes_q <= bytes_d;
			irow_q  <= irow_d;
			ileft_q <= ileft_d;
		end
	end

endmodule

FILE: rtl/tspd_out_reg.sv
`timescale 1ns / 1ps

module tspd_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  tspd_pkg::result_t result,
	output logic              advance,
	output logic              out_valid,
	input  logic              out_ready,
	output tspd_pkg::pixel_t  pixel_q
);
	import tspd_pkg::*;

	assign advance = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= step && result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step && result.valid) begin
			pixel_q <= result.pixel;
		end
	end

endmodule

FILE: rtl/tspd_checker.sv
`timescale 1ns / 1ps

module tspd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	// a held pixel stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("pixel changed while stalled");

	// an empty output register never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// a new pixel comes from a byte taken in through the input register
	a_pixel_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("pixel without a matching byte");

endmodule

bind tile_subtile_pixel_decoder tspd_checker u_tspd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
